// ===== rtl/hsc_pkg.sv =====
// Shared types, constants and jamo lookup tables for the Hangul syllable composer.
// No dependencies; every rtl file imports this package.
package hsc_pkg;

    // input item kinds
    localparam logic [1:0] KIND_JAMO  = 2'd0;
    localparam logic [1:0] KIND_ASCII = 2'd1;
    localparam logic [1:0] KIND_BACK  = 2'd2;

    // result item kinds
    localparam logic [1:0] RK_CHAR   = 2'd0;
    localparam logic [1:0] RK_DELETE = 2'd1;
    localparam logic [1:0] RK_STATUS = 2'd2;

    localparam logic [5:0]  NUM_CONS   = 6'd19;
    localparam logic [5:0]  NUM_JAMO   = 6'd40;
    localparam logic [15:0] SYL_BASE   = 16'hAC00;
    localparam logic [15:0] NUM_MEDIAL = 16'd21;
    localparam logic [15:0] NUM_FINAL  = 16'd28;
    localparam logic [15:0] VOWEL_BASE = 16'h314F;

    typedef struct packed {
        logic       has_i;
        logic [4:0] ii;
        logic       has_m;
        logic [4:0] mi;
        logic [4:0] fi;
    } t_syl;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] cp;
        logic        composing;
        logic        accepted;
        logic        last;
    } t_result;

    typedef struct packed {
        logic [1:0]        count;
        t_result [2:0]     res;
    } t_batch;

    typedef struct packed {
        logic       hit;
        logic [4:0] idx;
    } t_lookup;

    typedef struct packed {
        logic       hit;
        logic [4:0] stay;
        logic [4:0] moved;
    } t_split;

    function automatic logic [15:0] f_cons_compat(input logic [4:0] k);
        logic [15:0] r;
        case (k)
            5'd0:    r = 16'h3131;
            5'd1:    r = 16'h3132;
            5'd2:    r = 16'h3134;
            5'd3:    r = 16'h3137;
            5'd4:    r = 16'h3138;
            5'd5:    r = 16'h3139;
            5'd6:    r = 16'h3141;
            5'd7:    r = 16'h3142;
            5'd8:    r = 16'h3143;
            5'd9:    r = 16'h3145;
            5'd10:   r = 16'h3146;
            5'd11:   r = 16'h3147;
            5'd12:   r = 16'h3148;
            5'd13:   r = 16'h3149;
            5'd14:   r = 16'h314A;
            5'd15:   r = 16'h314B;
            5'd16:   r = 16'h314C;
            5'd17:   r = 16'h314D;
            5'd18:   r = 16'h314E;
            default: r = 16'h0000;
        endcase
        return r;
    endfunction

    // final index of a consonant key; zero when it cannot close a syllable
    function automatic logic [4:0] f_cons_as_final(input logic [4:0] k);
        logic [4:0] r;
        case (k)
            5'd0:    r = 5'd1;
            5'd1:    r = 5'd2;
            5'd2:    r = 5'd4;
            5'd3:    r = 5'd7;
            5'd5:    r = 5'd8;
            5'd6:    r = 5'd16;
            5'd7:    r = 5'd17;
            5'd9:    r = 5'd19;
            5'd10:   r = 5'd20;
            5'd11:   r = 5'd21;
            5'd12:   r = 5'd22;
            5'd14:   r = 5'd23;
            5'd15:   r = 5'd24;
            5'd16:   r = 5'd25;
            5'd17:   r = 5'd26;
            5'd18:   r = 5'd27;
            default: r = 5'd0;
        endcase
        return r;
    endfunction

    function automatic logic [4:0] f_final_to_initial(input logic [4:0] f);
        logic [4:0] r;
        case (f)
            5'd2:    r = 5'd1;
            5'd4:    r = 5'd2;
            5'd7:    r = 5'd3;
            5'd8:    r = 5'd5;
            5'd16:   r = 5'd6;
            5'd17:   r = 5'd7;
            5'd19:   r = 5'd9;
            5'd20:   r = 5'd10;
            5'd21:   r = 5'd11;
            5'd22:   r = 5'd12;
            5'd23:   r = 5'd14;
            5'd24:   r = 5'd15;
            5'd25:   r = 5'd16;
            5'd26:   r = 5'd17;
            5'd27:   r = 5'd18;
            5'd30:   r = 5'd1;
            default: r = 5'd0;
        endcase
        return r;
    endfunction

    function automatic t_lookup f_vowel_merge(input logic [4:0] a, input logic [4:0] b);
        t_lookup r;
        r.hit = 1'b1;
        case ({a, b})
            {5'd8, 5'd0}:   r.idx = 5'd9;
            {5'd8, 5'd1}:   r.idx = 5'd10;
            {5'd8, 5'd20}:  r.idx = 5'd11;
            {5'd13, 5'd4}:  r.idx = 5'd14;
            {5'd13, 5'd5}:  r.idx = 5'd15;
            {5'd13, 5'd20}: r.idx = 5'd16;
            {5'd18, 5'd20}: r.idx = 5'd19;
            {5'd0, 5'd20}:  r.idx = 5'd1;
            {5'd2, 5'd20}:  r.idx = 5'd3;
            {5'd4, 5'd20}:  r.idx = 5'd5;
            {5'd6, 5'd20}:  r.idx = 5'd7;
            default: begin
                r.hit = 1'b0;
                r.idx = 5'd0;
            end
        endcase
        return r;
    endfunction

    // compound vowel back to its first typed vowel
    function automatic t_lookup f_vowel_unmerge(input logic [4:0] m);
        t_lookup r;
        r.hit = 1'b1;
        case (m)
            5'd9, 5'd10, 5'd11:  r.idx = 5'd8;
            5'd14, 5'd15, 5'd16: r.idx = 5'd13;
            5'd19:               r.idx = 5'd18;
            5'd1:                r.idx = 5'd0;
            5'd3:                r.idx = 5'd2;
            5'd5:                r.idx = 5'd4;
            5'd7:                r.idx = 5'd6;
            default: begin
                r.hit = 1'b0;
                r.idx = 5'd0;
            end
        endcase
        return r;
    endfunction

    function automatic t_lookup f_final_merge(input logic [4:0] a, input logic [4:0] b);
        t_lookup r;
        r.hit = 1'b1;
        case ({a, b})
            {5'd1, 5'd19}:  r.idx = 5'd3;
            {5'd4, 5'd22}:  r.idx = 5'd5;
            {5'd4, 5'd27}:  r.idx = 5'd6;
            {5'd8, 5'd1}:   r.idx = 5'd9;
            {5'd8, 5'd16}:  r.idx = 5'd10;
            {5'd8, 5'd17}:  r.idx = 5'd11;
            {5'd8, 5'd19}:  r.idx = 5'd12;
            {5'd8, 5'd25}:  r.idx = 5'd13;
            {5'd8, 5'd26}:  r.idx = 5'd14;
            {5'd8, 5'd27}:  r.idx = 5'd15;
            {5'd17, 5'd19}: r.idx = 5'd18;
            default: begin
                r.hit = 1'b0;
                r.idx = 5'd0;
            end
        endcase
        return r;
    endfunction

    // compound final: part that stays and initial that moves on
    function automatic t_split f_split(input logic [4:0] f);
        t_split r;
        r.hit = 1'b1;
        case (f)
            5'd3:  begin r.stay = 5'd1;  r.moved = 5'd9;  end
            5'd5:  begin r.stay = 5'd4;  r.moved = 5'd12; end
            5'd6:  begin r.stay = 5'd4;  r.moved = 5'd18; end
            5'd9:  begin r.stay = 5'd8;  r.moved = 5'd0;  end
            5'd10: begin r.stay = 5'd8;  r.moved = 5'd6;  end
            5'd11: begin r.stay = 5'd8;  r.moved = 5'd7;  end
            5'd12: begin r.stay = 5'd8;  r.moved = 5'd9;  end
            5'd13: begin r.stay = 5'd8;  r.moved = 5'd16; end
            5'd14: begin r.stay = 5'd8;  r.moved = 5'd17; end
            5'd15: begin r.stay = 5'd8;  r.moved = 5'd18; end
            5'd18: begin r.stay = 5'd17; r.moved = 5'd9;  end
            default: begin
                r.hit   = 1'b0;
                r.stay  = 5'd0;
                r.moved = 5'd0;
            end
        endcase
        return r;
    endfunction

    // character shown for a syllable state; zero when nothing is held
    function automatic logic [15:0] f_preedit(input t_syl s);
        logic [15:0] lv;
        logic [15:0] r;
        lv = 16'(s.ii) * NUM_MEDIAL + 16'(s.mi);
        if (s.has_i && s.has_m) begin
            r = SYL_BASE + lv * NUM_FINAL + 16'(s.fi);
        end else if (s.has_i) begin
            r = f_cons_compat(s.ii);
        end else if (s.has_m) begin
            r = VOWEL_BASE + 16'(s.mi);
        end else begin
            r = 16'h0000;
        end
        return r;
    endfunction

endpackage

// ===== rtl/hsc_compose.sv =====
// Combinational composition step: next syllable state and the result batch for one key.
// Depends on hsc_pkg.
module hsc_compose (
    input  logic [1:0]    i_kind,
    input  logic [5:0]    i_key,
    input  logic [7:0]    i_ch,
    input  hsc_pkg::t_syl i_syl,
    output hsc_pkg::t_syl o_syl,
    output hsc_pkg::t_batch o_batch
);
    import hsc_pkg::*;

    logic [5:0] w_vsub;
    logic [4:0] w_vowel;
    logic [4:0] w_fin;
    t_lookup    w_vm;
    t_lookup    w_vu;
    t_lookup    w_fm;
    t_split     w_sp;

    t_syl        s;
    t_syl        settle_src;
    logic        settle_req;
    logic        extra_v;
    logic [1:0]  extra_kind;
    logic [15:0] extra_cp;
    logic        acc;
    logic        settle_v;
    t_result     res_settle;
    t_result     res_extra;
    t_result     res_status;

    assign w_vsub  = i_key - NUM_CONS;
    assign w_vowel = w_vsub[4:0];
    assign w_fin   = f_cons_as_final(i_key[4:0]);
    assign w_vm    = f_vowel_merge(i_syl.mi, w_vowel);
    assign w_vu    = f_vowel_unmerge(i_syl.mi);
    assign w_fm    = f_final_merge(i_syl.fi, w_fin);
    assign w_sp    = f_split(i_syl.fi);

    always_comb begin
        s          = i_syl;
        settle_src = i_syl;
        settle_req = 1'b0;
        extra_v    = 1'b0;
        extra_kind = RK_CHAR;
        extra_cp   = 16'h0000;
        acc        = 1'b1;
        case (i_kind)
            KIND_JAMO: begin
                if (i_key >= NUM_JAMO) begin
                    acc = 1'b0;
                end else if (i_key >= NUM_CONS) begin
                    if (!i_syl.has_i && !i_syl.has_m) begin
                        s.has_m = 1'b1;
                        s.mi    = w_vowel;
                    end else if (!i_syl.has_i || (i_syl.has_m && i_syl.fi == 5'd0)) begin
                        if (!i_syl.has_m) begin
                            s.has_m = 1'b1;
                            s.mi    = w_vowel;
                        end else if (w_vm.hit) begin
                            s.mi = w_vm.idx;
                        end else begin
                            settle_req = 1'b1;
                            s       = '0;
                            s.has_m = 1'b1;
                            s.mi    = w_vowel;
                        end
                    end else if (!i_syl.has_m) begin
                        s.has_m = 1'b1;
                        s.mi    = w_vowel;
                    end else begin
                        // carry the final, or half of a compound final, to a new syllable
                        settle_req    = 1'b1;
                        settle_src.fi = w_sp.hit ? w_sp.stay : 5'd0;
                        s.has_i = 1'b1;
                        s.ii    = w_sp.hit ? w_sp.moved : f_final_to_initial(i_syl.fi);
                        s.has_m = 1'b1;
                        s.mi    = w_vowel;
                        s.fi    = 5'd0;
                    end
                end else begin
                    if (i_syl.has_i && i_syl.has_m && w_fin != 5'd0 && i_syl.fi == 5'd0) begin
                        s.fi = w_fin;
                    end else if (i_syl.has_i && i_syl.has_m && w_fin != 5'd0 && w_fm.hit) begin
                        s.fi = w_fm.idx;
                    end else begin
                        settle_req = 1'b1;
                        s       = '0;
                        s.has_i = 1'b1;
                        s.ii    = i_key[4:0];
                    end
                end
            end
            KIND_ASCII: begin
                settle_req = 1'b1;
                s          = '0;
                extra_v    = 1'b1;
                extra_kind = RK_CHAR;
                extra_cp   = {8'h00, i_ch};
            end
            KIND_BACK: begin
                if (i_syl.fi != 5'd0) begin
                    s.fi = w_sp.hit ? w_sp.stay : 5'd0;
                end else if (i_syl.has_m) begin
                    if (w_vu.hit) begin
                        s.mi = w_vu.idx;
                    end else begin
                        s.has_m = 1'b0;
                        s.mi    = 5'd0;
                    end
                end else if (i_syl.has_i) begin
                    s.has_i = 1'b0;
                    s.ii    = 5'd0;
                end else begin
                    extra_v    = 1'b1;
                    extra_kind = RK_DELETE;
                end
            end
            default: begin
                acc = 1'b0;
            end
        endcase
    end

    assign settle_v = settle_req && (settle_src.has_i || settle_src.has_m);

    assign res_settle = '{kind: RK_CHAR, cp: f_preedit(settle_src), composing: 1'b0,
                          accepted: 1'b1, last: 1'b0};
    assign res_extra  = '{kind: extra_kind, cp: extra_cp, composing: 1'b0,
                          accepted: 1'b1, last: 1'b0};
    assign res_status = '{kind: RK_STATUS, cp: f_preedit(s), composing: s.has_i || s.has_m,
                          accepted: acc, last: 1'b1};

    // pack the results in emission order: settled syllable, extra, status
    assign o_batch.res[0] = settle_v ? res_settle : (extra_v ? res_extra : res_status);
    assign o_batch.res[1] = (settle_v && extra_v) ? res_extra : res_status;
    assign o_batch.res[2] = res_status;
    assign o_batch.count  = 2'd1 + {1'b0, settle_v} + {1'b0, extra_v};
    assign o_syl          = s;

endmodule

// ===== rtl/hsc_result_queue.sv =====
// Three-entry result queue that hands out one result per transfer.
// Depends on hsc_pkg.
module hsc_result_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  hsc_pkg::t_batch  i_batch,
    input  logic             i_ready,
    output logic             o_free,
    output logic             o_valid,
    output hsc_pkg::t_result o_res
);
    import hsc_pkg::*;

    logic [1:0]    r_left;
    t_result [2:0] r_q;
    logic          w_pop;

    assign w_pop   = (r_left != 2'd0) && i_ready;
    assign o_free  = (r_left == 2'd0) || (r_left == 2'd1 && i_ready);
    assign o_valid = r_left != 2'd0;
    assign o_res   = r_q[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left <= 2'd0;
        end else if (i_load) begin
            r_left <= i_batch.count;
        end else if (w_pop) begin
            r_left <= r_left - 2'd1;
        end
    end

    // advance the entries toward the head on every transfer
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_q <= i_batch.res;
        end else if (w_pop) begin
            r_q[0] <= r_q[1];
            r_q[1] <= r_q[2];
        end
    end

endmodule

// ===== rtl/hangul_syllable_composer.sv =====
// Top level of the Hangul two-set syllable composer: input register, syllable state,
// composition logic and result queue. Depends on hsc_pkg, hsc_compose, hsc_result_queue.
//
// Key events enter on the slave stream. Each one produces one to three results on the
// master stream, in this order:
//   - a settled character, when the held syllable is committed;
//   - a second item: an ASCII byte committed as is, or a delete-last request from a
//     backspace with nothing composed;
//   - always a status result with tlast high that carries the preedit character.
// An accepted item waits in the input register until the queue is free. Its whole batch
// is then computed in one pass and loaded into the result queue, which registers it and
// drives tvalid of the first result. The master side moves one result per cycle while
// tready is high, so an item with k results (one to three) occupies the output for k
// transfers; that single output port sets the sustained rate. A new item is taken while
// results still wait: the input register loads its item into the queue in the same cycle
// the queue's last entry leaves.
module hangul_syllable_composer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [5:0] jamo_key, [13:6] ascii_char, [15:14] zero
    input  logic [1:0]  s_axis_tuser,   // [1:0] kind
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // [15:0] code_point, [16] composing, [17] accepted
    output logic [1:0]  m_axis_tuser,   // [1:0] result_kind
    output logic        m_axis_tlast
);
    import hsc_pkg::*;

    logic       r_in_v;
    logic [1:0] r_kind;
    logic [5:0] r_key;
    logic [7:0] r_ch;
    t_syl       r_syl;

    t_syl    n_syl;
    t_batch  w_batch;
    logic    w_free;
    logic    w_load;
    t_result w_res;

    // the held item moves into the queue once the queue is empty or drains this cycle
    assign w_load        = r_in_v && w_free;
    assign s_axis_tready = !r_in_v || w_load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_v <= 1'b0;
        end else if (s_axis_tvalid && s_axis_tready) begin
            r_in_v <= 1'b1;
        end else if (w_load) begin
            r_in_v <= 1'b0;
        end
    end

    // hold the payload of the accepted transfer
    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_kind <= s_axis_tuser;
            r_key  <= s_axis_tdata[5:0];
            r_ch   <= s_axis_tdata[13:6];
        end
    end

    // advance the syllable state when an item's batch is loaded
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_syl <= '0;
        end else if (w_load) begin
            r_syl <= n_syl;
        end
    end

    hsc_compose u_compose (
        .i_kind  (r_kind),
        .i_key   (r_key),
        .i_ch    (r_ch),
        .i_syl   (r_syl),
        .o_syl   (n_syl),
        .o_batch (w_batch)
    );

    hsc_result_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (w_load),
        .i_batch (w_batch),
        .i_ready (m_axis_tready),
        .o_free  (w_free),
        .o_valid (m_axis_tvalid),
        .o_res   (w_res)
    );

    assign m_axis_tdata = {6'd0, w_res.accepted, w_res.composing, w_res.cp};
    assign m_axis_tuser = w_res.kind;
    assign m_axis_tlast = w_res.last;

endmodule

// ===== sim/hangul_syllable_composer_tb.sv =====
// Self-checking testbench for hangul_syllable_composer: a scoreboard class predicts every
// result from its own model of the two-set composing automaton and checks the result stream.
// Depends on hsc_pkg (kind codes, result type) and the composer RTL.
module hangul_syllable_composer_tb;
    import hsc_pkg::*;

    // kind code that the block must reject
    localparam logic [1:0] KIND_UNUSED = 2'd3;

    // Own model of the composer: syllable state, expected result queue, counters.
    class hangul_scoreboard;
        logic       has_init;
        logic [4:0] init_idx;
        logic       has_med;
        logic [4:0] med_idx;
        logic [4:0] fin_idx;
        t_result    pending[$];
        int         errors;
        int         results_seen;
        int         chars_seen;
        int         deletes_seen;

        function new();
            clear_syllable();
            errors       = 0;
            results_seen = 0;
            chars_seen   = 0;
            deletes_seen = 0;
        endfunction

        function void clear_syllable();
            has_init = 1'b0;
            init_idx = 5'd0;
            has_med  = 1'b0;
            med_idx  = 5'd0;
            fin_idx  = 5'd0;
        endfunction

        // compatibility jamo of a consonant key
        function logic [15:0] cons_cp(logic [4:0] k);
            case (k)
                5'd0, 5'd1:        return 16'h3131 + 16'(k);
                5'd2:              return 16'h3134;
                5'd3, 5'd4, 5'd5:  return 16'h3137 + 16'(k - 5'd3);
                5'd6, 5'd7, 5'd8:  return 16'h3141 + 16'(k - 5'd6);
                5'd9, 5'd10, 5'd11, 5'd12, 5'd13:
                                   return 16'h3145 + 16'(k - 5'd9);
                5'd14, 5'd15, 5'd16, 5'd17, 5'd18:
                                   return 16'h314A + 16'(k - 5'd14);
                default:           return 16'h0000;
            endcase
        endfunction

        // final index a consonant key closes a syllable with; zero when it cannot
        function logic [4:0] cons_final(logic [4:0] k);
            case (k)
                5'd0: return 5'd1;    5'd1: return 5'd2;    5'd2: return 5'd4;
                5'd3: return 5'd7;    5'd5: return 5'd8;    5'd6: return 5'd16;
                5'd7: return 5'd17;   5'd9: return 5'd19;   5'd10: return 5'd20;
                5'd11: return 5'd21;  5'd12: return 5'd22;  5'd14: return 5'd23;
                5'd15: return 5'd24;  5'd16: return 5'd25;  5'd17: return 5'd26;
                5'd18: return 5'd27;
                default: return 5'd0;
            endcase
        endfunction

        // simple final carried over as the next initial
        function logic [4:0] final_to_init(logic [4:0] f);
            case (f)
                5'd2: return 5'd1;    5'd4: return 5'd2;    5'd7: return 5'd3;
                5'd8: return 5'd5;    5'd16: return 5'd6;   5'd17: return 5'd7;
                5'd19: return 5'd9;   5'd20: return 5'd10;  5'd21: return 5'd11;
                5'd22: return 5'd12;  5'd23: return 5'd14;  5'd24: return 5'd15;
                5'd25: return 5'd16;  5'd26: return 5'd17;  5'd27: return 5'd18;
                default: return 5'd0;
            endcase
        endfunction

        // compound vowel of a typed pair, -1 when the pair does not merge
        function int vowel_join(logic [4:0] a, logic [4:0] b);
            if (a == 5'd8 && b == 5'd0)  return 9;
            if (a == 5'd8 && b == 5'd1)  return 10;
            if (a == 5'd13 && b == 5'd4) return 14;
            if (a == 5'd13 && b == 5'd5) return 15;
            if (b == 5'd20) begin
                case (a)
                    5'd8:  return 11;
                    5'd13: return 16;
                    5'd18: return 19;
                    5'd0, 5'd2, 5'd4, 5'd6: return int'(a) + 1;
                    default: return -1;
                endcase
            end
            return -1;
        endfunction

        // first typed vowel of a compound, -1 for a simple vowel
        function int vowel_first(logic [4:0] m);
            case (m)
                5'd9, 5'd10, 5'd11:     return 8;
                5'd14, 5'd15, 5'd16:    return 13;
                5'd19:                  return 18;
                5'd1, 5'd3, 5'd5, 5'd7: return int'(m) - 1;
                default:                return -1;
            endcase
        endfunction

        // compound final of a final pair, -1 when the pair does not merge
        function int final_join(logic [4:0] a, logic [4:0] b);
            case ({a, b})
                {5'd1, 5'd19}:  return 3;
                {5'd4, 5'd22}:  return 5;
                {5'd4, 5'd27}:  return 6;
                {5'd8, 5'd1}:   return 9;
                {5'd8, 5'd16}:  return 10;
                {5'd8, 5'd17}:  return 11;
                {5'd8, 5'd19}:  return 12;
                {5'd8, 5'd25}:  return 13;
                {5'd8, 5'd26}:  return 14;
                {5'd8, 5'd27}:  return 15;
                {5'd17, 5'd19}: return 18;
                default:        return -1;
            endcase
        endfunction

        // compound final: part that stays and initial that moves on
        function bit final_split(logic [4:0] f, output logic [4:0] stay,
                                 output logic [4:0] moved);
            stay  = 5'd8;
            moved = 5'd0;
            case (f)
                5'd3:  begin stay = 5'd1;  moved = 5'd9;  end
                5'd5:  begin stay = 5'd4;  moved = 5'd12; end
                5'd6:  begin stay = 5'd4;  moved = 5'd18; end
                5'd9:  moved = 5'd0;
                5'd10: moved = 5'd6;
                5'd11: moved = 5'd7;
                5'd12: moved = 5'd9;
                5'd13: moved = 5'd16;
                5'd14: moved = 5'd17;
                5'd15: moved = 5'd18;
                5'd18: begin stay = 5'd17; moved = 5'd9;  end
                default: return 1'b0;
            endcase
            return 1'b1;
        endfunction

        function logic [15:0] preedit_cp();
            int lv;
            lv = int'(init_idx) * 21 + int'(med_idx);
            if (has_init && has_med) return 16'(32'hAC00 + lv * 28 + int'(fin_idx));
            if (has_init)            return cons_cp(init_idx);
            if (has_med)             return 16'h314F + 16'(med_idx);
            return 16'h0000;
        endfunction

        function void push(logic [1:0] kind, logic [15:0] cp, logic comp, logic acc,
                           logic lst);
            t_result r;
            r.kind      = kind;
            r.cp        = cp;
            r.composing = comp;
            r.accepted  = acc;
            r.last      = lst;
            pending.push_back(r);
        endfunction

        // settle the held syllable, if any, as a committed character
        function void commit();
            if (has_init || has_med) push(RK_CHAR, preedit_cp(), 1'b0, 1'b1, 1'b0);
            clear_syllable();
        endfunction

        function void vowel_key(logic [4:0] v);
            int         m;
            logic [4:0] stay;
            logic [4:0] moved;
            if (!has_med) begin
                has_med = 1'b1;
                med_idx = v;
            end else if (!has_init || fin_idx == 5'd0) begin
                m = vowel_join(med_idx, v);
                if (m >= 0) begin
                    med_idx = 5'(m);
                end else begin
                    commit();
                    has_med = 1'b1;
                    med_idx = v;
                end
            end else begin
                // closed syllable: its final (or second half) opens the next one
                if (final_split(fin_idx, stay, moved)) begin
                    fin_idx = stay;
                end else begin
                    moved   = final_to_init(fin_idx);
                    fin_idx = 5'd0;
                end
                commit();
                has_init = 1'b1;
                init_idx = moved;
                has_med  = 1'b1;
                med_idx  = v;
            end
        endfunction

        function void consonant_key(logic [4:0] k);
            logic [4:0] fin;
            int         m;
            fin = cons_final(k);
            if (has_init && has_med && fin != 5'd0) begin
                if (fin_idx == 5'd0) begin
                    fin_idx = fin;
                    return;
                end
                m = final_join(fin_idx, fin);
                if (m >= 0) begin
                    fin_idx = 5'(m);
                    return;
                end
            end
            commit();
            has_init = 1'b1;
            init_idx = k;
        endfunction

        function void backspace();
            int         u;
            logic [4:0] stay;
            logic [4:0] moved;
            if (fin_idx != 5'd0) begin
                fin_idx = final_split(fin_idx, stay, moved) ? stay : 5'd0;
            end else if (has_med) begin
                u = vowel_first(med_idx);
                if (u >= 0) begin
                    med_idx = 5'(u);
                end else begin
                    has_med = 1'b0;
                    med_idx = 5'd0;
                end
            end else if (has_init) begin
                has_init = 1'b0;
                init_idx = 5'd0;
            end else begin
                push(RK_DELETE, 16'h0000, 1'b0, 1'b1, 1'b0);
            end
        endfunction

        // note one accepted key event and queue the results it causes
        function void note_input(logic [1:0] kind, logic [5:0] key, logic [7:0] ch);
            logic acc;
            acc = 1'b1;
            case (kind)
                KIND_JAMO: begin
                    if (key >= 6'd40)      acc = 1'b0;
                    else if (key >= 6'd19) vowel_key(5'(key - 6'd19));
                    else                   consonant_key(key[4:0]);
                end
                KIND_ASCII: begin
                    commit();
                    push(RK_CHAR, {8'h00, ch}, 1'b0, 1'b1, 1'b0);
                end
                KIND_BACK: backspace();
                default:   acc = 1'b0;
            endcase
            push(RK_STATUS, preedit_cp(), has_init || has_med, acc, 1'b1);
        endfunction

        function void compare_field(string what, logic [15:0] want, logic [15:0] got);
            if (got !== want) begin
                errors++;
                $display("%0t: %s mismatch, expected %h, actual %h",
                         $time, what, want, got);
            end
        endfunction

        // check one result transfer against the oldest expectation
        function void check_result(logic [1:0] kind, logic [15:0] cp, logic comp,
                                   logic acc, logic lst);
            t_result w;
            if (pending.size() == 0) begin
                errors++;
                $display("%0t: unexpected result, expected none, actual kind %0d cp %h",
                         $time, kind, cp);
                return;
            end
            w = pending.pop_front();
            results_seen++;
            if (w.kind == RK_CHAR)   chars_seen++;
            if (w.kind == RK_DELETE) deletes_seen++;
            compare_field("result_kind", 16'(w.kind), 16'(kind));
            compare_field("code_point", w.cp, cp);
            compare_field("composing", 16'(w.composing), 16'(comp));
            compare_field("accepted", 16'(w.accepted), 16'(acc));
            compare_field("last", 16'(w.last), 16'(lst));
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata;   // [5:0] jamo_key, [13:6] ascii_char, [15:14] zero
    logic [1:0]  s_axis_tuser;   // [1:0] kind
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [23:0] m_axis_tdata;   // [15:0] code_point, [16] composing, [17] accepted
    logic [1:0]  m_axis_tuser;   // [1:0] result_kind
    logic        m_axis_tlast;

    hangul_scoreboard sb;
    bit  no_idle;        // set for stretches where neither side idles
    int  keys_sent;      // every key event transferred
    int  useful_keys;    // key events the block acts on (not rejected)
    int  stall_left;

    hangul_syllable_composer u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Idle length for either side: mostly none or short, now and then long.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle) return 0;
        if (r < 55)  return 0;
        if (r < 85)  return $urandom_range(1, 3);
        if (r < 96)  return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Offer one key event and hold it until the transfer; tvalid is lowered only
    // for a gap, so back-to-back items keep it high with a single assignment.
    task automatic send_item(input logic [1:0] kind, input logic [5:0] key,
                             input logic [7:0] ch);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= kind;
        s_axis_tdata  <= {2'b00, ch, key};
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_input(kind, key, ch);
        keys_sent++;
        if (kind != KIND_UNUSED && !(kind == KIND_JAMO && key >= 6'd40)) useful_keys++;
    endtask

    // jamo key with garbage in the unused ascii field
    task automatic send_jamo(input int key);
        send_item(KIND_JAMO, 6'(key), 8'($urandom_range(0, 255)));
    endtask

    // Hold off the sender until every expected result has come back.
    task automatic wait_for_results();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (sb.pending.size() != 0);
    endtask

    // Type one syllable: initial, vowel, maybe a second vowel (one that merges where the first
    // has a partner), maybe a final and a second final (one that merges for some finals).
    task automatic type_syllable();
        int v;
        int w;
        int f;
        int liquid_pairs[7];
        liquid_pairs = '{0, 6, 7, 9, 16, 17, 18};
        send_jamo($urandom_range(0, 18));
        v = $urandom_range(0, 20);
        send_jamo(19 + v);
        if ($urandom_range(0, 99) < 40) begin
            case (v)
                8:       w = ($urandom_range(0, 2) == 0) ? 20 : $urandom_range(0, 1);
                13:      w = ($urandom_range(0, 2) == 0) ? 20 : $urandom_range(4, 5);
                0, 2, 4, 6, 18: w = 20;
                default: w = $urandom_range(0, 20);
            endcase
            send_jamo(19 + w);
        end
        if ($urandom_range(0, 99) < 65) begin
            case ($urandom_range(0, 9))
                0, 1:    f = 0;
                2, 3:    f = 2;
                4, 5:    f = 5;
                6:       f = 7;
                default: f = $urandom_range(0, 18);
            endcase
            send_jamo(f);
            if ($urandom_range(0, 99) < 45) begin
                case (f)
                    0, 7:    send_jamo(9);
                    2:       send_jamo($urandom_range(0, 1) ? 12 : 18);
                    5:       send_jamo(liquid_pairs[$urandom_range(0, 6)]);
                    default: send_jamo($urandom_range(0, 18));
                endcase
            end
        end
    endtask

    // Result side: random stalls; no new stall starts while no_idle is set.
    initial begin
        m_axis_tready <= 1'b0;
        stall_left = 0;
        forever begin
            @(posedge i_clk);
            if (stall_left > 0) begin
                m_axis_tready <= 1'b0;
                stall_left--;
            end else begin
                m_axis_tready <= 1'b1;
                if (!no_idle && $urandom_range(0, 99) < 25) stall_left = pick_gap();
            end
        end
    end

    // Check every result transfer against the scoreboard.
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tuser, m_axis_tdata[15:0], m_axis_tdata[16],
                            m_axis_tdata[17], m_axis_tlast);
    end

    initial begin
        int n;
        int r;
        sb = new();
        no_idle     = 1'b0;
        keys_sent   = 0;
        useful_keys = 0;
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= 16'h0000;
        s_axis_tuser  <= KIND_JAMO;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part: rejects, byte extremes, merges, carry-over, undo steps.
        send_item(KIND_BACK, 6'd0, 8'h00);          // empty: delete-last request
        send_item(KIND_UNUSED, 6'd63, 8'hFF);       // unused kind rejected
        send_jamo(40);                              // first out-of-range key
        send_jamo(63);
        send_item(KIND_ASCII, 6'd0, 8'h00);
        send_item(KIND_ASCII, 6'd63, 8'hFF);
        send_jamo(0);                               // initial
        send_jamo(19);                              // open syllable
        send_jamo(0);                               // simple final
        send_jamo(9);                               // compound final
        send_jamo(19);                              // second half moves on
        send_jamo(2);
        send_jamo(23);                              // whole simple final moves on
        send_jamo(8);                               // consonant that cannot close
        send_jamo(27);
        send_jamo(19);                              // compound vowel
        send_jamo(5);
        send_jamo(0);                               // compound final after merge vowel
        repeat (6) send_item(KIND_BACK, 6'h2A, 8'h55);  // undo down to empty and past
        send_jamo(39);                              // lone vowel
        send_jamo(19);                              // vowels that do not merge
        send_jamo(18);                              // consonant after lone vowel
        send_item(KIND_ASCII, 6'h15, 8'h41);        // settle plus byte: three results
        wait_for_results();

        // Random part: mostly typed syllables, some undo, bytes and noise.
        while (keys_sent < 216) begin
            r = $urandom_range(0, 99);
            if (r < 62) begin
                type_syllable();
            end else if (r < 74) begin
                repeat ($urandom_range(1, 4))
                    send_item(KIND_BACK, 6'($urandom_range(0, 63)),
                              8'($urandom_range(0, 255)));
            end else if (r < 82) begin
                send_item(KIND_ASCII, 6'($urandom_range(0, 63)), 8'($urandom_range(0, 255)));
            end else begin
                send_item(2'($urandom_range(0, 3)), 6'($urandom_range(0, 63)),
                          8'($urandom_range(0, 255)));
            end
            if ($urandom_range(0, 14) == 0) no_idle = !no_idle;
            if ($urandom_range(0, 29) == 0) wait_for_results();
        end

        // Drain, then allow for the pipeline before declaring leftovers.
        s_axis_tvalid <= 1'b0;
        for (n = 0; n < 20000 && sb.pending.size() != 0; n++) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (sb.pending.size() != 0) begin
            $display("%0t: %0d expected results never arrived", $time, sb.pending.size());
            sb.errors++;
        end

        $display("Sent %0d key events (%0d acted on); checked %0d results.",
                 keys_sent, useful_keys, sb.results_seen);
        $display("Among them %0d committed characters and %0d delete requests; %0d errors.",
                 sb.chars_seen, sb.deletes_seen, sb.errors);
        if (sb.errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // Watchdog far above the slowest legal run.
    initial begin
        #2000000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ===== hangul_syllable_composer.f =====
rtl/hsc_pkg.sv
rtl/hsc_compose.sv
rtl/hsc_result_queue.sv
rtl/hangul_syllable_composer.sv
sim/hangul_syllable_composer_tb.sv
